FILE: rtl/core/indexed_sequence_store_unit_assert.svh
// Assertion macros used by the indexed sequence store RTL.
`ifndef INDEXED_SEQUENCE_STORE_UNIT_ASSERT_SVH
`define INDEXED_SEQUENCE_STORE_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define ISSU_ASSERT_NOW(label, clk, rst, cond, conseq, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define ISSU_ASSERT_NEXT(label, clk, rst, cond, conseq, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
      else $error(msg);

`endif

FILE: rtl/core/isss_pkg.sv
// Types and constants of the indexed sequence store.
package isss_pkg;

   localparam int ITEM_WIDTH  = 32;
   localparam int POS_WIDTH   = 5;
   localparam int COUNT_WIDTH = 5;

   typedef enum logic [2:0] {
      OP_GET    = 3'd0,
      OP_HEAD   = 3'd1,
      OP_TAIL   = 3'd2,
      OP_INSERT = 3'd3,
      OP_DELETE = 3'd4
   } opcode_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // Command broadcast to every cell of the chain.
   typedef enum logic [1:0] {
      CMD_HOLD   = 2'd0,
      CMD_INSERT = 2'd1,
      CMD_DELETE = 2'd2
   } cell_cmd_type;

   typedef struct packed {
      opcode_type                    opcode;
      logic [POS_WIDTH-1:0]          position;
      logic signed [ITEM_WIDTH-1:0]  item_value;
   } req_payload_type;

   typedef struct packed {
      logic signed [ITEM_WIDTH-1:0]  read_value;
      status_type                    status;
      logic [COUNT_WIDTH-1:0]        element_count;
   } rsp_payload_type;

endpackage

FILE: rtl/core/indexed_sequence_store_unit.sv
// Indexed sequence store: a chain of value cells with an element count.
//
// Holds an ordered sequence of up to CAPACITY values and serves get, add at head,
// add at tail, insert at index and delete at index. Every request transaction
// gives exactly one response transaction. Every cell of the chain decides on its
// own whether to hold, load the new value, or take its left or right neighbor's
// value, so all cells of a shift over the whole sequence update together. The
// response is registered; a new request is taken in the same cycle as the
// pending response is taken, so the block sustains one transaction per clock
// while the response side keeps taking responses. No clearing pass follows
// reset; slots past the count are never read.
module indexed_sequence_store_unit #(
   parameter int CAPACITY    = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  isss_pkg::req_payload_type  req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output isss_pkg::rsp_payload_type  rsp_payload
);

`include "indexed_sequence_store_unit_assert.svh"

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = (CW > isss_pkg::POS_WIDTH) ? CW : isss_pkg::POS_WIDTH;
   localparam int IW = isss_pkg::ITEM_WIDTH;
   localparam logic [PW-1:0] CAP_X = PW'(CAPACITY);

   logic [CW-1:0]                count_ff;
   logic [CW-1:0]                count_in;
   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   isss_pkg::rsp_payload_type    rsp_data_ff;
   isss_pkg::rsp_payload_type    rsp_data_in;

   logic                         req_accept;
   logic [PW-1:0]                pos_x;
   logic [PW-1:0]                cnt_x;
   logic [PW-1:0]                eff_pos;
   isss_pkg::cell_cmd_type       cmd;
   logic [PW-1:0]                cmd_at;
   logic [VALUE_WIDTH-1:0]       load_value;
   logic [VALUE_WIDTH-1:0]       cell_data [CAPACITY];
   logic [VALUE_WIDTH-1:0]       read_raw;
   logic [IW-1:0]                read_item;
   logic                         insert_go;

   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;
   assign pos_x      = PW'(req_payload.position);
   assign cnt_x      = PW'(count_ff);

   // Conversion between the item width and the stored width.
   generate
      if (VALUE_WIDTH <= IW) begin : g_narrow
         assign load_value = req_payload.item_value[VALUE_WIDTH-1:0];
         assign read_item  = IW'(read_raw);
      end else begin : g_wide
         assign load_value = VALUE_WIDTH'(req_payload.item_value);
         assign read_item  = read_raw[IW-1:0];
      end
   endgenerate

   // Read port: select the addressed cell.
   always_comb begin
      read_raw = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (pos_x == PW'(i)) begin
            read_raw = cell_data[i];
         end
      end
   end

   // Decode the request transaction into a chain command and a response.
   always_comb begin
      cmd                       = isss_pkg::CMD_HOLD;
      cmd_at                    = pos_x;
      count_in                  = count_ff;
      insert_go                 = 1'b0;
      rsp_data_in.read_value    = '0;
      rsp_data_in.status        = isss_pkg::ST_DONE;
      eff_pos                   = pos_x;
      unique case (req_payload.opcode)
         isss_pkg::OP_GET: begin
            if (pos_x < cnt_x) begin
               rsp_data_in.read_value = read_item;
            end else begin
               rsp_data_in.read_value = '1;
               rsp_data_in.status     = isss_pkg::ST_RANGE;
            end
         end
         isss_pkg::OP_HEAD, isss_pkg::OP_TAIL, isss_pkg::OP_INSERT: begin
            if (req_payload.opcode == isss_pkg::OP_HEAD) begin
               eff_pos = '0;
            end else if (req_payload.opcode == isss_pkg::OP_TAIL) begin
               eff_pos = cnt_x;
            end
            if (eff_pos > cnt_x) begin
               rsp_data_in.status = isss_pkg::ST_RANGE;
            end else if (cnt_x == CAP_X) begin
               rsp_data_in.status = isss_pkg::ST_FULL;
            end else begin
               insert_go = 1'b1;
               cmd       = isss_pkg::CMD_INSERT;
               cmd_at    = eff_pos;
               count_in  = count_ff + CW'(1);
            end
         end
         isss_pkg::OP_DELETE: begin
            if (pos_x < cnt_x) begin
               cmd      = isss_pkg::CMD_DELETE;
               count_in = count_ff - CW'(1);
            end else begin
               rsp_data_in.status = isss_pkg::ST_RANGE;
            end
         end
         default: begin
            cmd = isss_pkg::CMD_HOLD;
         end
      endcase
      if (!req_accept) begin
         cmd      = isss_pkg::CMD_HOLD;
         count_in = count_ff;
      end
      rsp_data_in.element_count = isss_pkg::COUNT_WIDTH'(count_in);
   end

   // Chain of cells; each cell sees its two neighbors.
   generate
      for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
         logic [VALUE_WIDTH-1:0] left_value;
         logic [VALUE_WIDTH-1:0] right_value;
         if (i == 0) begin : g_first
            assign left_value = '0;
         end else begin : g_left
            assign left_value = cell_data[i-1];
         end
         if (i == CAPACITY - 1) begin : g_last
            assign right_value = '0;
         end else begin : g_right
            assign right_value = cell_data[i+1];
         end
         isss_cell #(
            .VALUE_WIDTH (VALUE_WIDTH),
            .INDEX       (i),
            .PW          (PW)
         ) u_cell (
            .clock       (clock),
            .cmd         (cmd),
            .at          (cmd_at),
            .count       (cnt_x),
            .load_value  (load_value),
            .left_value  (left_value),
            .right_value (right_value),
            .data        (cell_data[i])
         );
      end
   endgenerate

   // Response register: loads on a request transaction, empties when taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   // Checks on the count and the response.
   `ISSU_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(CAPACITY), "count above capacity")
   `ISSU_ASSERT_NEXT(a_count_idle, clock, reset, !req_accept, $stable(count_ff), "count moved without a transaction")
   `ISSU_ASSERT_NEXT(a_insert_grows, clock, reset, req_accept && insert_go, count_ff == $past(count_ff) + CW'(1), "insert did not grow the count")
   `ISSU_ASSERT_NOW(a_full_status, clock, reset, rsp_valid_ff && (rsp_data_ff.status == isss_pkg::ST_FULL), count_ff == CW'(CAPACITY), "full status with room left")

endmodule

FILE: rtl/core/isss_cell.sv
// One slot of the element chain: holds, loads, or takes a neighbor's value.
module isss_cell #(
   parameter int VALUE_WIDTH = 32,
   parameter int INDEX       = 0,
   parameter int PW          = 5
) (
   input  logic                    clock,
   input  isss_pkg::cell_cmd_type  cmd,
   input  logic [PW-1:0]           at,
   input  logic [PW-1:0]           count,
   input  logic [VALUE_WIDTH-1:0]  load_value,
   input  logic [VALUE_WIDTH-1:0]  left_value,
   input  logic [VALUE_WIDTH-1:0]  right_value,
   output logic [VALUE_WIDTH-1:0]  data
);

   localparam logic [PW-1:0] SLOT = PW'(INDEX);
   localparam logic [PW-1:0] NEXT = PW'(INDEX + 1);

   logic [VALUE_WIDTH-1:0] data_ff;
   logic [VALUE_WIDTH-1:0] data_in;

   // Local decision: open a gap by taking the left value, close one by taking the right.
   always_comb begin
      data_in = data_ff;
      unique case (cmd)
         isss_pkg::CMD_INSERT: begin
            if (SLOT == at) begin
               data_in = load_value;
            end else if ((SLOT > at) && (SLOT <= count)) begin
               data_in = left_value;
            end
         end
         isss_pkg::CMD_DELETE: begin
            if ((SLOT >= at) && (NEXT < count)) begin
               data_in = right_value;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule
